FILE: hdl/stl_pkg.sv
// Shared codes for the sorted timer list manager.
`timescale 1ns / 1ps
package stl_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_BIND       = 3'd2,
    OP_ARM        = 3'd3,
    OP_CANCEL     = 3'd4,
    OP_CANCEL_ALL = 3'd5,
    OP_TICK       = 3'd6
  } op_e;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_NOT_RUN = 2'd2;
  localparam logic [1:0] STAT_BAD     = 2'd3;

  localparam logic [1:0] SS_FREE  = 2'd0;
  localparam logic [1:0] SS_ALLOC = 2'd1;
  localparam logic [1:0] SS_RUN   = 2'd2;

  localparam int unsigned MAX_RESULTS = 64;

  // pool size, tied to the 6-bit slot fields
  localparam int TIMER_SLOTS = 64;

endpackage

FILE: hdl/sorted_timer_list_manager.sv
// Timer slot pool with a due-ordered linked list of running timers.
//
// Input channel: in_valid_i / in_stall_o carry one command (operation, slot,
// queue, data, delay, auto-cancel flag). Output channel: out_valid_o /
// out_stall_i carry results; every command gives one result, a tick gives
// one result per expired slot (at most 64), the final one marked by last_o.
// Commands are handled one at a time by a small sequencer around single-port
// slot memories (read data registered), so in_stall_o is high while one runs.
// Free, cancel and arm first unlink a running slot, walking the list one memory
// read per hop; an arm then inserts the slot by walking from the head. Alloc scans
// slots from 1 for a free one; cancel_all scans slots from 1 and frees each one
// with auto-cancel set and the given queue, unlinking it if running; a tick walks
// from the head and takes the expired slots one after another.
// After reset the block sweeps the slot memories and holds in_stall_o high;
// configuration writes are taken throughout.
// A result waits in the output register while out_stall_i is high; the next
// command is accepted meanwhile, and the sequencer waits only when it must
// present another result.
`timescale 1ns / 1ps
module sorted_timer_list_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [5:0]  slot_i,
  input  logic [7:0]  queue_id_i,
  input  logic [31:0] event_data_i,
  input  logic [31:0] delay_ticks_i,
  input  logic        auto_cancel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  result_slot_o,
  output logic        event_valid_o,
  output logic [7:0]  event_queue_o,
  output logic [31:0] event_word_o,
  output logic        task_switch_o,
  output logic        last_o
);
  import stl_pkg::*;

  localparam int SW = $clog2(TIMER_SLOTS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_DEC, S_AL_RD, S_AL_CK, S_CA_RD, S_CA_CK,
    S_UL0, S_UL1, S_UL2, S_UL3, S_POST, S_IN0, S_IN1, S_IN3, S_IN4,
    S_TK0, S_TK1, S_DONE
  } state_e;

  // slot memories
  logic [2:0]    meta_mem [TIMER_SLOTS];  // {auto_cancel, slot state}
  logic [31:0]   due_mem  [TIMER_SLOTS];
  logic [SW-1:0] link_mem [TIMER_SLOTS];
  logic [7:0]    dq_mem   [TIMER_SLOTS];
  logic [31:0]   pw_mem   [TIMER_SLOTS];

  logic [2:0]    meta_rq;
  logic [31:0]   due_rq, pw_rq;
  logic [SW-1:0] link_rq;
  logic [7:0]    dq_rq;

  state_e        state_q;
  logic [SW:0]   idx_q;
  logic [SW-1:0] cnt_q, cur_q, prev_q, us_q, ls_q, head_q;
  logic [2:0]    op_q;
  logic [5:0]    slot_q, sw_q;
  logic [7:0]    q_q;
  logic [31:0]   data_q, delay_q, d_q, tick_q, next_due_q;
  logic          ac_q;
  logic [2:0]    meta_q;
  logic [1:0]    res_st_q;
  logic [5:0]    res_slot_q;
  logic [6:0]    n_q;
  logic          pend_v_q, ts_acc_q, pev_q;
  logic [5:0]    pslot_q;
  logic [7:0]    pq_q;
  logic [31:0]   pw_q;

  logic          out_valid_q, ev_q, ts_q, last_q;
  logic [1:0]    status_q;
  logic [5:0]    rslot_q;
  logic [7:0]    eq_q;
  logic [31:0]   ew_q;

  logic [SW-1:0] ra, sidx;
  logic          in_bad, out_free, tk_exp, tk_adv, tk_ev, ca_last, out_load;
  logic [31:0]   arm_due;

  logic          meta_we, due_we, link_we, bind_we;
  logic [SW-1:0] meta_wa, due_wa, link_wa;
  logic [2:0]    meta_wd;
  logic [31:0]   due_wd;
  logic [SW-1:0] link_wd;
  logic [1:0]    post_st;

  assign sidx     = SW'(slot_q);
  assign in_bad   = (slot_i == 6'd0) || (32'(slot_i) >= 32'(TIMER_SLOTS));
  assign out_free = !out_valid_q || !out_stall_i;
  assign tk_exp   = (cur_q != '0) && (due_rq <= tick_q) && (n_q < 7'(MAX_RESULTS));
  assign tk_adv   = tk_exp && (!pend_v_q || out_free);
  assign tk_ev    = (32'(cur_q) != 32'(sw_q));
  assign ca_last  = (idx_q == (SW+1)'(TIMER_SLOTS - 1));
  assign arm_due  = tick_q + delay_q;
  // output register takes a new transfer this cycle
  assign out_load = out_free && (((state_q == S_TK1) && pend_v_q) || (state_q == S_DONE));

  always_comb begin
    case (op_q)
      OP_ARM:    post_st = SS_RUN;
      OP_CANCEL: post_st = SS_ALLOC;
      default:   post_st = SS_FREE;
    endcase
  end

  // read address for all slot memories
  always_comb begin
    unique case (state_q)
      S_RD:               ra = sidx;
      S_AL_RD, S_CA_RD:   ra = idx_q[SW-1:0];
      S_UL0:              ra = us_q;
      S_UL1:              ra = (head_q == us_q) ? link_rq : head_q;
      S_UL3, S_IN1, S_IN3: ra = link_rq;
      S_IN0, S_TK0:       ra = head_q;
      S_TK1:              ra = tk_adv ? link_rq : cur_q;
      default:            ra = '0;
    endcase
  end

  // memory write ports
  always_comb begin
    meta_we = 1'b0;
    meta_wa = us_q;
    meta_wd = '0;
    due_we  = 1'b0;
    due_wa  = us_q;
    due_wd  = arm_due;
    link_we = 1'b0;
    link_wa = us_q;
    link_wd = cur_q;
    bind_we = 1'b0;
    unique case (state_q)
      S_CLR: begin
        meta_we = 1'b1;
        meta_wa = idx_q[SW-1:0];
        meta_wd = (idx_q == '0) ? {1'b0, SS_RUN} : 3'b000;
        due_we  = (idx_q == '0);
        due_wa  = '0;
        due_wd  = '1;
      end
      S_AL_CK: begin
        meta_we = (meta_rq[1:0] == SS_FREE);
        meta_wa = idx_q[SW-1:0];
        meta_wd = {1'b0, SS_ALLOC};
      end
      S_DEC: begin
        if (op_q == OP_BIND && meta_rq[1:0] != SS_FREE) begin
          meta_we = 1'b1;
          bind_we = 1'b1;
        end
        meta_wa = sidx;
        meta_wd = {ac_q, meta_rq[1:0]};
      end
      S_POST: begin
        meta_we = 1'b1;
        meta_wd = {meta_q[2], post_st};
        due_we  = (op_q == OP_ARM);
      end
      S_UL3: begin
        link_we = (link_rq == us_q);
        link_wa = cur_q;
        link_wd = ls_q;
      end
      S_IN1: begin
        link_we = (d_q <= due_rq);
        link_wd = head_q;
      end
      S_IN3: begin
        link_we = (d_q <= due_rq) || (cur_q == '0);
        link_wa = prev_q;
        link_wd = us_q;
      end
      S_IN4: link_we = 1'b1;
      S_TK1: begin
        meta_we = tk_adv;
        meta_wa = cur_q;
        meta_wd = {meta_rq[2], SS_ALLOC};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (due_we)  due_mem[due_wa]   <= due_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (bind_we) begin
      dq_mem[sidx] <= q_q;
      pw_mem[sidx] <= data_q;
    end
    meta_rq <= meta_mem[ra];
    due_rq  <= due_mem[ra];
    link_rq <= link_mem[ra];
    dq_rq   <= dq_mem[ra];
    pw_rq   <= pw_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      us_q        <= '0;
      ls_q        <= '0;
      head_q      <= '0;
      op_q        <= '0;
      slot_q      <= '0;
      sw_q        <= '0;
      q_q         <= '0;
      data_q      <= '0;
      delay_q     <= '0;
      d_q         <= '0;
      tick_q      <= '0;
      next_due_q  <= '1;
      ac_q        <= 1'b0;
      meta_q      <= '0;
      res_st_q    <= STAT_OK;
      res_slot_q  <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      ts_acc_q    <= 1'b0;
      pev_q       <= 1'b0;
      pslot_q     <= '0;
      pq_q        <= '0;
      pw_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STAT_OK;
      rslot_q     <= '0;
      ev_q        <= 1'b0;
      eq_q        <= '0;
      ew_q        <= '0;
      ts_q        <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) sw_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLR: begin
          if (idx_q == (SW+1)'(TIMER_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
          idx_q <= idx_q + 1'b1;
        end

        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= operation_i;
            slot_q   <= slot_i;
            q_q      <= queue_id_i;
            data_q   <= event_data_i;
            delay_q  <= delay_ticks_i;
            ac_q     <= auto_cancel_i;
            res_st_q <= STAT_OK;
            res_slot_q <= '0;
            idx_q    <= (SW+1)'(1);
            case (operation_i)
              OP_ALLOC:      state_q <= S_AL_RD;
              OP_CANCEL_ALL: state_q <= S_CA_RD;
              OP_TICK: begin
                tick_q  <= tick_q + 1'b1;
                state_q <= S_TK0;
              end
              OP_FREE, OP_BIND, OP_ARM, OP_CANCEL: begin
                if (in_bad) begin
                  res_st_q <= STAT_BAD;
                  state_q  <= S_DONE;
                end else begin
                  state_q  <= S_RD;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end

        S_RD: state_q <= S_DEC;

        S_DEC: begin
          meta_q <= meta_rq;
          us_q   <= sidx;
          case (op_q)
            OP_FREE: state_q <= (meta_rq[1:0] == SS_RUN) ? S_UL0 : S_POST;
            OP_BIND: begin
              if (meta_rq[1:0] == SS_FREE) res_st_q <= STAT_BAD;
              state_q <= S_DONE;
            end
            OP_ARM: begin
              if (meta_rq[1:0] == SS_FREE) begin
                res_st_q <= STAT_BAD;
                state_q  <= S_DONE;
              end else begin
                state_q  <= (meta_rq[1:0] == SS_RUN) ? S_UL0 : S_POST;
              end
            end
            default: begin
              if (meta_rq[1:0] != SS_RUN) begin
                res_st_q <= STAT_NOT_RUN;
                state_q  <= S_DONE;
              end else begin
                state_q  <= S_UL0;
              end
            end
          endcase
        end

        S_AL_RD: state_q <= S_AL_CK;

        S_AL_CK: begin
          if (meta_rq[1:0] == SS_FREE) begin
            res_slot_q <= 6'(idx_q[SW-1:0]);
            state_q    <= S_DONE;
          end else if (ca_last) begin
            res_st_q <= STAT_NO_FREE;
            state_q  <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_AL_RD;
          end
        end

        S_CA_RD: state_q <= S_CA_CK;

        S_CA_CK: begin
          meta_q <= meta_rq;
          us_q   <= idx_q[SW-1:0];
          if (meta_rq[1:0] != SS_FREE && meta_rq[2] && dq_rq == q_q) begin
            state_q <= (meta_rq[1:0] == SS_RUN) ? S_UL0 : S_POST;
          end else if (ca_last) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_CA_RD;
          end
        end

        // unlink us_q from the running list
        S_UL0: state_q <= S_UL1;

        S_UL1: begin
          ls_q <= link_rq;
          if (head_q == us_q) begin
            head_q  <= link_rq;
            state_q <= S_UL2;
          end else begin
            cur_q   <= head_q;
            cnt_q   <= '0;
            state_q <= S_UL3;
          end
        end

        S_UL2: begin
          next_due_q <= due_rq;
          state_q    <= S_POST;
        end

        S_UL3: begin
          if (link_rq == us_q || cur_q == '0 || cnt_q == SW'(TIMER_SLOTS - 1)) begin
            state_q <= S_POST;
          end else begin
            cur_q <= link_rq;
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_POST: begin
          case (op_q)
            OP_ARM: begin
              d_q     <= arm_due;
              state_q <= S_IN0;
            end
            OP_CANCEL_ALL: begin
              if (ca_last) begin
                state_q <= S_DONE;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= S_CA_RD;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end

        // insert us_q by due time, newest first among equals
        S_IN0: state_q <= S_IN1;

        S_IN1: begin
          if (d_q <= due_rq) begin
            head_q     <= us_q;
            next_due_q <= d_q;
            state_q    <= S_DONE;
          end else begin
            prev_q  <= head_q;
            cur_q   <= link_rq;
            cnt_q   <= '0;
            state_q <= S_IN3;
          end
        end

        S_IN3: begin
          if (d_q <= due_rq || cur_q == '0) begin
            state_q <= S_IN4;
          end else if (cnt_q == SW'(TIMER_SLOTS - 1)) begin
            state_q <= S_DONE;
          end else begin
            prev_q <= cur_q;
            cur_q  <= link_rq;
            cnt_q  <= cnt_q + 1'b1;
          end
        end

        S_IN4: state_q <= S_DONE;

        S_TK0: begin
          cur_q    <= head_q;
          n_q      <= '0;
          pend_v_q <= 1'b0;
          ts_acc_q <= 1'b0;
          state_q  <= (next_due_q <= tick_q) ? S_TK1 : S_DONE;
        end

        // one expired slot per cycle while the output is free; the newest one is held back
        // until we know whether it is the final transfer
        S_TK1: begin
          if (tk_exp) begin
            if (tk_adv) begin
              if (pend_v_q) begin
                out_valid_q <= 1'b1;
                status_q    <= STAT_OK;
                rslot_q     <= pslot_q;
                ev_q        <= pev_q;
                eq_q        <= pq_q;
                ew_q        <= pw_q;
                ts_q        <= 1'b0;
                last_q      <= 1'b0;
              end
              pend_v_q <= 1'b1;
              pslot_q  <= 6'(cur_q);
              pev_q    <= tk_ev;
              pq_q     <= tk_ev ? dq_rq : 8'd0;
              pw_q     <= tk_ev ? pw_rq : 32'd0;
              if (!tk_ev) ts_acc_q <= 1'b1;
              n_q      <= n_q + 1'b1;
              cur_q    <= link_rq;
            end
          end else if (!pend_v_q) begin
            head_q     <= cur_q;
            next_due_q <= due_rq;
            state_q    <= S_DONE;
          end else if (out_free) begin
            head_q      <= cur_q;
            next_due_q  <= due_rq;
            out_valid_q <= 1'b1;
            status_q    <= STAT_OK;
            rslot_q     <= pslot_q;
            ev_q        <= pev_q;
            eq_q        <= pq_q;
            ew_q        <= pw_q;
            ts_q        <= ts_acc_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_st_q;
            rslot_q     <= res_slot_q;
            ev_q        <= 1'b0;
            eq_q        <= '0;
            ew_q        <= '0;
            ts_q        <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign result_slot_o = rslot_q;
  assign event_valid_o = ev_q;
  assign event_queue_o = eq_q;
  assign event_word_o  = ew_q;
  assign task_switch_o = ts_q;
  assign last_o        = last_q;

endmodule

FILE: hdl/stl_checker.sv
// Port-level checks for the sorted timer list manager, bound to the top level.
`timescale 1ns / 1ps
module stl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [5:0]  result_slot_o,
  input logic        event_valid_o,
  input logic [7:0]  event_queue_o,
  input logic [31:0] event_word_o,
  input logic        task_switch_o,
  input logic        last_o
);
  import stl_pkg::*;

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_slot_o)
      && $stable(event_word_o) && $stable(last_o))
    else $error("output changed while stalled");

  a_ts_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && task_switch_o |-> last_o && status_o == STAT_OK)
    else $error("task switch off the final result");

  a_ev_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> status_o == STAT_OK && result_slot_o != 6'd0)
    else $error("event without an expired slot");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> last_o && !event_valid_o
      && event_queue_o == 8'd0)
    else $error("error result not a single final result");

endmodule

bind sorted_timer_list_manager stl_checker u_stl_checker (.*);
